/* rtl/deq_pkg.sv */
`timescale 1ns / 1ps

package deq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int WORD_W    = 32;

	typedef enum logic [1:0] {
		KIND_PUSH_FRONT = 2'd0,
		KIND_PUSH_REAR  = 2'd1,
		KIND_POP_FRONT  = 2'd2,
		KIND_POP_REAR   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// where a cell takes its next word from
	typedef enum logic [1:0] {
		SEL_HOLD = 2'd0,
		SEL_LOW  = 2'd1,
		SEL_HIGH = 2'd2,
		SEL_PUSH = 2'd3
	} cell_sel_t;

	typedef struct packed {
		cell_sel_t sel;
		logic      tap;
	} cell_ctrl_t;

endpackage

/* rtl/deq_cell.sv */
`timescale 1ns / 1ps

module deq_cell (
	input  logic                                clk,
	input  deq_pkg::cell_ctrl_t                 ctrl,
	input  logic signed [deq_pkg::WORD_W-1:0]   low_data,
	input  logic signed [deq_pkg::WORD_W-1:0]   high_data,
	input  logic signed [deq_pkg::WORD_W-1:0]   push_data,
	output logic signed [deq_pkg::WORD_W-1:0]   data_q,
	output logic signed [deq_pkg::WORD_W-1:0]   tap_data
);

	always_ff @(posedge clk) begin
		case (ctrl.sel)
			deq_pkg::SEL_LOW:  data_q <= low_data;
			deq_pkg::SEL_HIGH: data_q <= high_data;
			deq_pkg::SEL_PUSH: data_q <= push_data;
			default:           data_q <= data_q;
		endcase
	end

	// only the rear cell drives the or-tree for a rear pop
	assign tap_data = ctrl.tap ? data_q : '0;

endmodule

/* rtl/double_ended_queue_core.sv */
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit words, held in a row of cells.
// The front entry always sits in cell 0 and the entries follow in order, so a
// front push shifts the whole row up and a front pop shifts it down, while a
// rear push loads the cell just past the last entry.
// Command channel: kind and push_value are taken at a rising edge with start
// high and busy low. busy stays low, so one command may be issued per cycle.
// Result channel: in the cycle after each transfer, done is high for exactly one
// cycle with pop_value, status and entry_count. The receiver cannot stall, so
// it must take every result in that cycle.
// Throughput is one command per cycle; the cell row updates in the same edge
// that registers the result.
// status: ok, pop on an empty queue (pop_value 0), or push on a full queue
// (the word is dropped). entry_count is the count after the command.
// Reset clears the count and the result strobe; cell contents are not reset
// and are only read after a push has written them.
module double_ended_queue_core #(
	parameter int  DEPTH = deq_pkg::DEPTH_DEF,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        kind,
	input  logic signed [deq_pkg::WORD_W-1:0] push_value,
	output logic                              done,
	output logic signed [deq_pkg::WORD_W-1:0] pop_value,
	output logic [1:0]                        status,
	output logic [CNT_W-1:0]                  entry_count
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic [CNT_W-1:0] rear_idx;
	logic             acc;
	logic             full;
	logic             empty;
	logic             do_pf;
	logic             do_pr;
	logic             do_popf;
	logic             do_popr;
	logic             done_q;
	logic signed [deq_pkg::WORD_W-1:0] pop_value_q;
	logic signed [deq_pkg::WORD_W-1:0] pop_nxt;
	logic signed [deq_pkg::WORD_W-1:0] rear_word;
	deq_pkg::status_t status_q;
	deq_pkg::status_t status_nxt;
	deq_pkg::kind_t   kind_c;

	logic signed [deq_pkg::WORD_W-1:0] cell_data [DEPTH];
	logic signed [deq_pkg::WORD_W-1:0] cell_tap  [DEPTH];
	deq_pkg::cell_ctrl_t               cell_ctrl [DEPTH];

	assign busy   = 1'b0;
	assign acc    = start && !busy;
	assign kind_c = deq_pkg::kind_t'(kind);
	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign rear_idx = count_q - CNT_W'(1);

	assign do_pf   = acc && (kind_c == deq_pkg::KIND_PUSH_FRONT) && !full;
	assign do_pr   = acc && (kind_c == deq_pkg::KIND_PUSH_REAR)  && !full;
	assign do_popf = acc && (kind_c == deq_pkg::KIND_POP_FRONT)  && !empty;
	assign do_popr = acc && (kind_c == deq_pkg::KIND_POP_REAR)   && !empty;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [deq_pkg::WORD_W-1:0] low_w;
		logic signed [deq_pkg::WORD_W-1:0] high_w;

		if (i == 0) begin : g_first
			assign low_w = push_value;
		end else begin : g_mid_low
			assign low_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign high_w = cell_data[i];
		end else begin : g_mid_high
			assign high_w = cell_data[i+1];
		end

		always_comb begin
			cell_ctrl[i].tap = (rear_idx == CNT_W'(i));
			if (do_pf) begin
				cell_ctrl[i].sel = deq_pkg::SEL_LOW;
			end else if (do_popf) begin
				cell_ctrl[i].sel = deq_pkg::SEL_HIGH;
			end else if (do_pr && (count_q == CNT_W'(i))) begin
				cell_ctrl[i].sel = deq_pkg::SEL_PUSH;
			end else begin
				cell_ctrl[i].sel = deq_pkg::SEL_HOLD;
			end
		end

		deq_cell u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl[i]),
			.low_data  (low_w),
			.high_data (high_w),
			.push_data (push_value),
			.data_q    (cell_data[i]),
			.tap_data  (cell_tap[i])
		);
	end

	always_comb begin
		rear_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rear_word = rear_word | cell_tap[i];
		end
	end

	always_comb begin
		count_nxt  = count_q;
		pop_nxt    = '0;
		status_nxt = deq_pkg::ST_OK;
		case (kind_c)
			deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_REAR: begin
				if (full) begin
					status_nxt = deq_pkg::ST_FULL;
				end else begin
					count_nxt = count_q + CNT_W'(1);
				end
			end
			deq_pkg::KIND_POP_FRONT: begin
				if (empty) begin
					status_nxt = deq_pkg::ST_EMPTY;
				end else begin
					pop_nxt   = cell_data[0];
					count_nxt = count_q - CNT_W'(1);
				end
			end
			default: begin
				if (empty) begin
					status_nxt = deq_pkg::ST_EMPTY;
				end else begin
					pop_nxt   = rear_word;
					count_nxt = count_q - CNT_W'(1);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= acc;
			if (acc) begin
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pop_value_q <= pop_nxt;
			status_q    <= status_nxt;
		end
	end

	assign done        = done_q;
	assign pop_value   = pop_value_q;
	assign status      = status_q;
	assign entry_count = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start))
		else $error("result strobe without a command transfer");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == deq_pkg::ST_FULL) |-> (entry_count == CNT_W'(DEPTH)))
		else $error("full status with room left");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == deq_pkg::ST_EMPTY) |-> (entry_count == '0 && pop_value == '0))
		else $error("empty status with entries held or nonzero word");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> $stable(count_q))
		else $error("entry count moved without a transfer");

endmodule
